// ===== design/tpfc_pkg.sv =====
package tpfc_pkg;

    // palette selector codes, anything else falls back to jet
    localparam logic [1:0] PAL_JET  = 2'd0;
    localparam logic [1:0] PAL_GRAY = 2'd1;
    localparam logic [1:0] PAL_IRON = 2'd2;

    // register indexes on the apb port (byte address = 4 * index)
    localparam int unsigned APB_ADDR_W = 5;
    localparam logic [2:0] REG_PALETTE_MODE = 3'd0;
    localparam logic [2:0] REG_PIXEL_FORMAT = 3'd1;
    localparam logic [2:0] REG_SCALED_MIN   = 3'd2;
    localparam logic [2:0] REG_SCALED_MAX   = 3'd3;
    localparam logic [2:0] REG_RANGE_LOW    = 3'd4;
    localparam logic [2:0] REG_RANGE_HIGH   = 3'd5;

    // pixel formats
    localparam logic FMT_RAW16  = 1'b0;
    localparam logic FMT_SCALE8 = 1'b1;

    // valid band limits, exclusive
    localparam logic [15:0] BAND_LOW  = 16'd1000;
    localparam logic [15:0] BAND_HIGH = 16'd30000;

    // rounding term and divisor of the 8-bit expansion
    localparam logic [23:0] EXP_ROUND = 24'd127;
    localparam logic [23:0] EXP_DIV   = 24'd255;

    // level bits produced by the divider
    localparam int unsigned LVL_W = 8;

    typedef struct packed {
        logic [1:0]  palette_mode;
        logic        pixel_format;
        logic [15:0] scaled_min;
        logic [15:0] scaled_max;
        logic [15:0] range_low;
        logic [15:0] range_high;
    } t_cfg;

endpackage

// ===== design/tpfc_pix_if.sv =====
interface tpfc_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

// ===== design/tpfc_rgb_if.sv =====
interface tpfc_rgb_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] decoded_value;
    logic        in_valid_band;
    logic        frame_end_out;

    modport source (
        output valid, output red, output green, output blue,
        output decoded_value, output in_valid_band, output frame_end_out,
        input ready
    );
    modport sink (
        input valid, input red, input green, input blue,
        input decoded_value, input in_valid_band, input frame_end_out,
        output ready
    );
endinterface

// ===== design/tpfc_decode.sv =====
module tpfc_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpfc_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [15:0]     i_sample,
    input  logic            i_frame_end,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_value,
    output logic            o_frame_end
);

    // stage 1: product, stage 2: reciprocal estimate, stage 3: correction and select
    logic        r_v1, r_v2, r_v3;
    logic [15:0] r_sample1, r_sample2;
    logic        r_fe1, r_fe2, r_fe3;
    logic [23:0] r_num1, r_num2;
    logic [15:0] r_q0;
    logic [15:0] r_value;

    logic        w_en1, w_en2, w_en3;
    logic [15:0] w_span;
    logic [23:0] n_num1;
    logic [24:0] w_sum;
    logic [15:0] n_q0;
    logic [23:0] w_q255;
    logic [23:0] w_rem;
    logic [15:0] w_q;
    logic        w_scale;
    logic [15:0] n_value;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    assign w_scale = i_cfg.scaled_max > i_cfg.scaled_min;
    assign w_span  = i_cfg.scaled_max - i_cfg.scaled_min;
    assign n_num1  = 24'(i_sample[7:0]) * 24'(w_span) + tpfc_pkg::EXP_ROUND;

    // x/255 ~ (x + x/256 + x/65536)/256, never high and at most one low
    assign w_sum = 25'(r_num1) + 25'(r_num1 >> 8) + 25'(r_num1 >> 16);
    assign n_q0  = 16'(w_sum >> 8);

    assign w_q255 = {r_q0, 8'h00} - {8'h00, r_q0};
    assign w_rem  = r_num2 - w_q255;
    assign w_q    = r_q0 + 16'(w_rem >= tpfc_pkg::EXP_DIV);

    always_comb begin
        if (i_cfg.pixel_format == tpfc_pkg::FMT_RAW16) begin
            n_value = r_sample2;
        end else if (w_scale) begin
            n_value = i_cfg.scaled_min + w_q;
        end else begin
            n_value = {r_sample2[7:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_sample1 <= i_sample;
            r_fe1     <= i_frame_end;
            r_num1    <= n_num1;
        end
        if (w_en2) begin
            r_sample2 <= r_sample1;
            r_fe2     <= r_fe1;
            r_num2    <= r_num1;
            r_q0      <= n_q0;
        end
        if (w_en3) begin
            r_value <= n_value;
            r_fe3   <= r_fe2;
        end
    end

    assign o_valid     = r_v3;
    assign o_value     = r_value;
    assign o_frame_end = r_fe3;

endmodule

// ===== design/tpfc_norm.sv =====
module tpfc_norm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tpfc_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [15:0]                   i_value,
    input  logic                          i_frame_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tpfc_pkg::LVL_W-1:0]    o_level,
    output logic [15:0]                   o_value,
    output logic                          o_frame_end
);

    localparam int unsigned NS = tpfc_pkg::LVL_W + 1;

    // offset and span stage
    logic        r_va;
    logic [15:0] r_x;
    logic [15:0] r_da;
    logic [15:0] r_vala;
    logic        r_fea;

    // stage 0 holds the scaled numerator, stages 1..8 each resolve one quotient bit
    logic                       r_sv  [NS];
    logic [15:0]                r_rem [NS];
    logic [7:0]                 r_lo  [NS];
    logic [tpfc_pkg::LVL_W-1:0] r_q   [NS];
    logic                       r_sat [NS];
    logic [15:0]                r_d   [NS];
    logic [15:0]                r_val [NS];
    logic                       r_fe  [NS];

    logic [15:0]                n_rem [NS];
    logic [7:0]                 n_lo  [NS];
    logic [tpfc_pkg::LVL_W-1:0] n_q   [NS];

    logic        w_en [NS];
    logic        w_ena;
    logic        w_above;
    logic [15:0] n_x;
    logic [15:0] n_d;
    logic [23:0] w_num;
    logic        n_sat;

    assign w_en[NS-1] = !r_sv[NS-1] || i_ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign w_en[k] = !r_sv[k] || w_en[k+1];
    end
    assign w_ena   = !r_va || w_en[0];
    assign o_ready = w_ena;

    assign w_above = i_value > i_cfg.range_low;
    assign n_x     = w_above ? (i_value - i_cfg.range_low) : 16'd0;
    assign n_d     = (i_cfg.range_high > i_cfg.range_low) ?
                     (i_cfg.range_high - i_cfg.range_low) : 16'd1;

    // x * 255, saturate when the quotient would need a ninth bit
    assign w_num = {r_x, 8'h00} - {8'h00, r_x};
    assign n_sat = w_num[23:8] >= r_da;

    always_comb begin
        logic [16:0] t;
        logic        ge;
        n_rem[0] = w_num[23:8];
        n_lo[0]  = w_num[7:0];
        n_q[0]   = '0;
        for (int k = 1; k < NS; k++) begin
            t        = {r_rem[k-1], r_lo[k-1][7]};
            ge       = t >= {1'b0, r_d[k-1]};
            n_rem[k] = ge ? 16'(t - {1'b0, r_d[k-1]}) : t[15:0];
            n_lo[k]  = {r_lo[k-1][6:0], 1'b0};
            n_q[k]   = {r_q[k-1][tpfc_pkg::LVL_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else begin
            if (w_ena) r_va <= i_valid;
            if (w_en[0]) r_sv[0] <= r_va;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_sv[k] <= r_sv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ena) begin
            r_x    <= n_x;
            r_da   <= n_d;
            r_vala <= i_value;
            r_fea  <= i_frame_end;
        end
        if (w_en[0]) begin
            r_rem[0] <= n_rem[0];
            r_lo[0]  <= n_lo[0];
            r_q[0]   <= n_q[0];
            r_sat[0] <= n_sat;
            r_d[0]   <= r_da;
            r_val[0] <= r_vala;
            r_fe[0]  <= r_fea;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_q[k]   <= n_q[k];
                r_sat[k] <= r_sat[k-1];
                r_d[k]   <= r_d[k-1];
                r_val[k] <= r_val[k-1];
                r_fe[k]  <= r_fe[k-1];
            end
        end
    end

    assign o_valid     = r_sv[NS-1];
    assign o_level     = r_sat[NS-1] ? '1 : r_q[NS-1];
    assign o_value     = r_val[NS-1];
    assign o_frame_end = r_fe[NS-1];

endmodule

// ===== design/tpfc_palette.sv =====
module tpfc_palette (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tpfc_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tpfc_pkg::LVL_W-1:0]    i_level,
    input  logic [15:0]                   i_value,
    input  logic                          i_frame_end,
    tpfc_rgb_if.source                    o_rgb
);

    logic        r_v;
    logic [7:0]  r_red, r_green, r_blue;
    logic [15:0] r_value;
    logic        r_band;
    logic        r_fe;

    logic        w_en;
    logic [7:0]  n_red, n_green, n_blue;
    logic        n_band;
    logic [7:0]  w_off4, w_off2, w_low6;

    assign w_en    = !r_v || o_rgb.ready;
    assign o_ready = w_en;

    // offsets within the current quarter of the level range
    assign w_off4 = {i_level[5:0], 2'b00};
    assign w_off2 = {1'b0, i_level[5:0], 1'b0};
    assign w_low6 = {2'b00, i_level[5:0]};

    assign n_band = (i_value > tpfc_pkg::BAND_LOW) && (i_value < tpfc_pkg::BAND_HIGH);

    always_comb begin
        n_red   = i_level;
        n_green = i_level;
        n_blue  = i_level;
        case (i_cfg.palette_mode)
            tpfc_pkg::PAL_GRAY: begin
                n_red   = i_level;
                n_green = i_level;
                n_blue  = i_level;
            end
            tpfc_pkg::PAL_IRON: begin
                case (i_level[7:6])
                    2'd0: begin
                        n_red   = w_off2;
                        n_green = 8'd0;
                        n_blue  = w_low6;
                    end
                    2'd1: begin
                        n_red   = {1'b1, i_level[5:0], 1'b0};
                        n_green = w_low6;
                        n_blue  = 8'd128 - i_level;
                    end
                    2'd2: begin
                        n_red   = 8'd255;
                        n_green = 8'd64 + w_off2;
                        n_blue  = 8'd0;
                    end
                    default: begin
                        n_red   = 8'd255;
                        n_green = i_level;
                        n_blue  = w_off2;
                    end
                endcase
            end
            default: begin
                // jet, also for the unused selector code
                case (i_level[7:6])
                    2'd0: begin
                        n_red   = 8'd0;
                        n_green = w_off4;
                        n_blue  = 8'd255;
                    end
                    2'd1: begin
                        n_red   = 8'd0;
                        n_green = 8'd255;
                        n_blue  = 8'd255 - w_off4;
                    end
                    2'd2: begin
                        n_red   = w_off4;
                        n_green = 8'd255;
                        n_blue  = 8'd0;
                    end
                    default: begin
                        n_red   = 8'd255;
                        n_green = 8'd255 - w_off4;
                        n_blue  = 8'd0;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_value <= i_value;
            r_band  <= n_band;
            r_fe    <= i_frame_end;
        end
    end

    assign o_rgb.valid         = r_v;
    assign o_rgb.red           = r_red;
    assign o_rgb.green         = r_green;
    assign o_rgb.blue          = r_blue;
    assign o_rgb.decoded_value = r_value;
    assign o_rgb.in_valid_band = r_band;
    assign o_rgb.frame_end_out = r_fe;

endmodule

// ===== design/thermal_pixel_false_color.sv =====
// thermal false colour mapper: takes one sensor pixel per clock on i_pix and delivers one
// rgb pixel per clock on o_rgb while o_rgb takes them, together with the decoded 16-bit
// value, a flag for values strictly between 1000 and 30000, and the frame end mark. a
// pixel passes 14 register stages (3 for format decoding, 10 for normalisation, 1 for
// the palette) on its way to o_rgb; the depth is set by the level divider, which
// resolves one quotient bit per stage. every stage holds its own valid bit and fills
// bubbles, so the input keeps taking pixels while a finished result waits on o_rgb, until
// every stage is full. the six apb registers (palette mode, pixel format, scaled
// min/max, display range low/high) sit at byte addresses 0x00..0x14 and must only be
// written while no pixel is in flight.
module thermal_pixel_false_color (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tpfc_pix_if.sink                            i_pix,
    tpfc_rgb_if.source                          o_rgb,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tpfc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    tpfc_pkg::t_cfg r_cfg;

    logic        w_wr;
    logic [2:0]  w_idx;

    // decode -> normalise
    logic        w_dec_valid, w_dec_ready;
    logic [15:0] w_dec_value;
    logic        w_dec_fe;

    // normalise -> palette
    logic                          w_nrm_valid, w_nrm_ready;
    logic [tpfc_pkg::LVL_W-1:0]    w_nrm_level;
    logic [15:0]                   w_nrm_value;
    logic                          w_nrm_fe;

    // apb: no wait states, register written in the access phase
    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.palette_mode <= tpfc_pkg::PAL_JET;
            r_cfg.pixel_format <= tpfc_pkg::FMT_RAW16;
            r_cfg.scaled_min   <= 16'd0;
            r_cfg.scaled_max   <= 16'd0;
            r_cfg.range_low    <= 16'd0;
            r_cfg.range_high   <= 16'd1;
        end else if (w_wr) begin
            case (w_idx)
                tpfc_pkg::REG_PALETTE_MODE: r_cfg.palette_mode <= pwdata[1:0];
                tpfc_pkg::REG_PIXEL_FORMAT: r_cfg.pixel_format <= pwdata[0];
                tpfc_pkg::REG_SCALED_MIN:   r_cfg.scaled_min   <= pwdata[15:0];
                tpfc_pkg::REG_SCALED_MAX:   r_cfg.scaled_max   <= pwdata[15:0];
                tpfc_pkg::REG_RANGE_LOW:    r_cfg.range_low    <= pwdata[15:0];
                tpfc_pkg::REG_RANGE_HIGH:   r_cfg.range_high   <= pwdata[15:0];
                default: ;  // unmapped addresses are ignored
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (w_idx)
            tpfc_pkg::REG_PALETTE_MODE: prdata = 32'(r_cfg.palette_mode);
            tpfc_pkg::REG_PIXEL_FORMAT: prdata = 32'(r_cfg.pixel_format);
            tpfc_pkg::REG_SCALED_MIN:   prdata = 32'(r_cfg.scaled_min);
            tpfc_pkg::REG_SCALED_MAX:   prdata = 32'(r_cfg.scaled_max);
            tpfc_pkg::REG_RANGE_LOW:    prdata = 32'(r_cfg.range_low);
            tpfc_pkg::REG_RANGE_HIGH:   prdata = 32'(r_cfg.range_high);
            default:                    prdata = 32'd0;
        endcase
    end

    // 8-bit expansion between scaled min and max or to the top byte, raw samples pass
    tpfc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_pix.valid),
        .o_ready     (i_pix.ready),
        .i_sample    (i_pix.sample),
        .i_frame_end (i_pix.frame_end),
        .o_valid     (w_dec_valid),
        .i_ready     (w_dec_ready),
        .o_value     (w_dec_value),
        .o_frame_end (w_dec_fe)
    );

    // display range to level 0..255, pipelined restoring divider
    tpfc_norm u_norm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_dec_valid),
        .o_ready     (w_dec_ready),
        .i_value     (w_dec_value),
        .i_frame_end (w_dec_fe),
        .o_valid     (w_nrm_valid),
        .i_ready     (w_nrm_ready),
        .o_level     (w_nrm_level),
        .o_value     (w_nrm_value),
        .o_frame_end (w_nrm_fe)
    );

    // palette lookup, band flag and output register
    tpfc_palette u_palette (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_nrm_valid),
        .o_ready     (w_nrm_ready),
        .i_level     (w_nrm_level),
        .i_value     (w_nrm_value),
        .i_frame_end (w_nrm_fe),
        .o_rgb       (o_rgb)
    );

endmodule

// ===== design/tpfc_checker.sv =====
module tpfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_red,
    input logic [7:0]  i_green,
    input logic [7:0]  i_blue,
    input logic [15:0] i_value,
    input logic        i_band,
    input logic        i_fe
);

    // a result offered stays offered until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transfer");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_red) && $stable(i_green) && $stable(i_blue) &&
            $stable(i_value) && $stable(i_band) && $stable(i_fe))
        else $error("stalled output changed");

    // band flag agrees with the decoded value it travels with
    a_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_band == ((i_value > 16'd1000) && (i_value < 16'd30000))))
        else $error("band flag inconsistent with decoded value");

    // reset empties the pipeline
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind thermal_pixel_false_color tpfc_checker u_tpfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue),
    .i_value     (o_rgb.decoded_value),
    .i_band      (o_rgb.in_valid_band),
    .i_fe        (o_rgb.frame_end_out)
);

// ===== bench/thermal_pixel_false_color_tb.sv =====
`timescale 1ns / 100ps

module thermal_pixel_false_color_tb;

    // bench timing
    localparam int unsigned CLK_PERIOD = 20;
    localparam int unsigned PIPE_DEPTH = 14;
    localparam int unsigned MAX_GAP    = 17;

    // random sweep shape, roughly 800 pixels in all
    localparam int unsigned RANDOM_PHASES    = 16;
    localparam int unsigned PIXELS_PER_PHASE = 50;

    localparam int unsigned REPORT_LIMIT = 10;

    // palette code with no palette of its own, the block falls back to jet
    localparam logic [1:0] PAL_SPARE = 2'd3;

    // register indexes past the register file, writes there are dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // one coloured pixel as it leaves the block
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] decoded;
        logic        band;
        logic        frame_end;
    } t_rgb_pix;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tpfc_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    tpfc_pix_if pix_bus();
    tpfc_rgb_if rgb_bus();

    thermal_pixel_false_color u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_rgb   (rgb_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // our own copy of the register file, only changed while the pipe is empty
    tpfc_pkg::t_cfg cfg_shadow;

    // colours still owed by the block, oldest first
    t_rgb_pix colour_q[$];

    // idling switches for the pixel source and the colour sink
    bit src_idle;
    bit snk_idle;

    int unsigned pixels_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned settings_used;

    // free-running clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop if the pipe hangs, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // colour prediction
    // ------------------------------------------------------------------

    // raw samples pass, byte samples are stretched between the frame min and max, rounded
    function automatic logic [15:0] expand_sample(logic [15:0] s);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] p;
        logic [31:0] sum;
        lo = 32'(cfg_shadow.scaled_min);
        hi = 32'(cfg_shadow.scaled_max);
        p  = 32'(s[7:0]);
        if (cfg_shadow.pixel_format == tpfc_pkg::FMT_RAW16)
            return s;
        if (hi > lo) begin
            sum = lo + (p * (hi - lo) + 32'd127) / 32'd255;
            return sum[15:0];
        end
        // empty or inverted frame span: byte goes to the top of the word
        return {s[7:0], 8'h00};
    endfunction

    // display range normalisation, truncated and saturated to one byte
    function automatic logic [7:0] level_of_value(logic [15:0] v);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] span;
        logic [31:0] q;
        lo   = 32'(cfg_shadow.range_low);
        hi   = 32'(cfg_shadow.range_high);
        // a collapsed or inverted range behaves as a span of one
        span = (hi > lo) ? hi - lo : 32'd1;
        if ({16'd0, v} <= lo)
            return 8'd0;
        q = (({16'd0, v} - lo) * 32'd255) / span;
        return (q > 32'd255) ? 8'd255 : q[7:0];
    endfunction

    function automatic t_rgb_pix map_pixel(logic [15:0] s, logic fe);
        t_rgb_pix    res;
        logic [15:0] v;
        int          lv;
        int          r;
        int          g;
        int          b;
        v  = expand_sample(s);
        lv = int'(level_of_value(v));
        case (cfg_shadow.palette_mode)
            tpfc_pkg::PAL_GRAY: begin
                r = lv;
                g = lv;
                b = lv;
            end
            tpfc_pkg::PAL_IRON: begin
                // black through purple and red to white-hot yellow
                if (lv < 64) begin
                    r = 2 * lv;
                    g = 0;
                    b = lv;
                end else if (lv < 128) begin
                    r = 128 + 2 * (lv - 64);
                    g = lv - 64;
                    b = 128 - lv;
                end else if (lv < 192) begin
                    r = 255;
                    g = 64 + 2 * (lv - 128);
                    b = 0;
                end else begin
                    r = 255;
                    g = lv;
                    b = 2 * (lv - 192);
                end
            end
            default: begin
                // jet, also taken by the spare palette code
                if (lv < 64) begin
                    r = 0;
                    g = 4 * lv;
                    b = 255;
                end else if (lv < 128) begin
                    r = 0;
                    g = 255;
                    b = 255 - 4 * (lv - 64);
                end else if (lv < 192) begin
                    r = 4 * (lv - 128);
                    g = 255;
                    b = 0;
                end else begin
                    r = 255;
                    g = 255 - 4 * (lv - 192);
                    b = 0;
                end
            end
        endcase
        res.red       = r[7:0];
        res.green     = g[7:0];
        res.blue      = b[7:0];
        res.decoded   = v;
        res.band      = (v > tpfc_pkg::BAND_LOW) && (v < tpfc_pkg::BAND_HIGH);
        res.frame_end = fe;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // pixel source and colour sink
    // ------------------------------------------------------------------

    // valid stays up between back-to-back pixels, it only drops for a gap
    task automatic send_pixel(input logic [15:0] s, input logic fe);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid     <= 1'b1;
        pix_bus.sample    <= s;
        pix_bus.frame_end <= fe;
        do @(posedge i_clk); while (!pix_bus.ready);
        // registers are stable while pixels are in flight, so predict now
        colour_q.insert(colour_q.size(), map_pixel(s, fe));
        pixels_sent++;
    endtask

    // called at a transfer edge on o_rgb, values are the pre-edge ones
    task automatic check_result();
        t_rgb_pix got;
        t_rgb_pix want;
        got = {rgb_bus.red, rgb_bus.green, rgb_bus.blue, rgb_bus.decoded_value,
               rgb_bus.in_valid_band, rgb_bus.frame_end_out};
        results_seen++;
        if (colour_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: o_rgb transfer with no pixel outstanding", $time);
        end else begin
            want = colour_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: colour mismatch, expected rgb %0d/%0d/%0d %s",
                             $time, want.red, want.green, want.blue,
                             $sformatf("value %0d band %0b end %0b",
                                       want.decoded, want.band, want.frame_end));
                    $display("%0t:                    got rgb %0d/%0d/%0d %s",
                             $time, got.red, got.green, got.blue,
                             $sformatf("value %0d band %0b end %0b",
                                       got.decoded, got.band, got.frame_end));
                end
            end
        end
    endtask

    // sink: a fresh stall draw for every colour, ready held until it lands
    initial begin : colour_sink
        int unsigned gap;
        rgb_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0) begin
                rgb_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rgb_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rgb_bus.valid);
            check_result();
        end
    end

    // stop feeding pixels and wait for every owed colour
    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (colour_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    // setup, access, then an idle phase with psel low so accesses never share an edge
    task automatic apb_access(input logic [2:0] idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] reg_value(logic [2:0] idx);
        case (idx)
            tpfc_pkg::REG_PALETTE_MODE: return {30'd0, cfg_shadow.palette_mode};
            tpfc_pkg::REG_PIXEL_FORMAT: return {31'd0, cfg_shadow.pixel_format};
            tpfc_pkg::REG_SCALED_MIN:   return {16'd0, cfg_shadow.scaled_min};
            tpfc_pkg::REG_SCALED_MAX:   return {16'd0, cfg_shadow.scaled_max};
            tpfc_pkg::REG_RANGE_LOW:    return {16'd0, cfg_shadow.range_low};
            tpfc_pkg::REG_RANGE_HIGH:   return {16'd0, cfg_shadow.range_high};
            default:                    return 32'd0;
        endcase
    endfunction

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] got;
        apb_access(idx, 1'b0, 32'd0, got);
        if (got !== reg_value(idx)) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: register %0d reads %h, expected %h",
                         $time, idx, got, reg_value(idx));
        end
    endtask

    // write one register, mirror it, and read it back where it exists
    task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
        logic [31:0] unused;
        apb_access(idx, 1'b1, {16'd0, val}, unused);
        case (idx)
            tpfc_pkg::REG_PALETTE_MODE: cfg_shadow.palette_mode = val[1:0];
            tpfc_pkg::REG_PIXEL_FORMAT: cfg_shadow.pixel_format = val[0];
            tpfc_pkg::REG_SCALED_MIN:   cfg_shadow.scaled_min   = val;
            tpfc_pkg::REG_SCALED_MAX:   cfg_shadow.scaled_max   = val;
            tpfc_pkg::REG_RANGE_LOW:    cfg_shadow.range_low    = val;
            tpfc_pkg::REG_RANGE_HIGH:   cfg_shadow.range_high   = val;
            default: ;
        endcase
        if (idx <= tpfc_pkg::REG_RANGE_HIGH)
            check_reg(idx);
    endtask

    // drain the pipe, then load a complete setting
    task automatic program_all(input logic [1:0] pal, input logic fmt,
                               input logic [15:0] smin, input logic [15:0] smax,
                               input logic [15:0] lo, input logic [15:0] hi);
        settle();
        set_reg(tpfc_pkg::REG_PALETTE_MODE, {14'd0, pal});
        set_reg(tpfc_pkg::REG_PIXEL_FORMAT, {15'd0, fmt});
        set_reg(tpfc_pkg::REG_SCALED_MIN, smin);
        set_reg(tpfc_pkg::REG_SCALED_MAX, smax);
        set_reg(tpfc_pkg::REG_RANGE_LOW, lo);
        set_reg(tpfc_pkg::REG_RANGE_HIGH, hi);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // random picks
    // ------------------------------------------------------------------

    // 16-bit register value leaning on both ends of the scale
    function automatic logic [15:0] draw_word();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // sample aimed at the interesting parts of the current setting
    function automatic logic [15:0] draw_sample();
        logic [15:0] s;
        logic [15:0] lo;
        logic [15:0] hi;
        s  = 16'($urandom_range(0, 16'hFFFF));
        lo = cfg_shadow.range_low;
        hi = cfg_shadow.range_high;
        if (lo > hi) begin
            lo = cfg_shadow.range_high;
            hi = cfg_shadow.range_low;
        end
        if (cfg_shadow.pixel_format == tpfc_pkg::FMT_SCALE8) begin
            // high byte stays random, it must be ignored
            case ($urandom_range(0, 7))
                0:       s[7:0] = 8'h00;
                1:       s[7:0] = 8'hFF;
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 7))
                0:       s = lo;
                1:       s = hi;
                2:       s = 16'(tpfc_pkg::BAND_LOW + $urandom_range(0, 1));
                3:       s = 16'(tpfc_pkg::BAND_HIGH - $urandom_range(0, 1));
                4, 5, 6: s = 16'(lo + $urandom_range(0, hi - lo));
                default: ;
            endcase
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register file after reset, and pixels through the reset setting
    task automatic test_reset_state();
        for (int i = tpfc_pkg::REG_PALETTE_MODE; i <= tpfc_pkg::REG_RANGE_HIGH; i++)
            check_reg(i[2:0]);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b1);
    endtask

    // identity normalisation so the sample is the level, then the palette bends
    task automatic test_palette_edges();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        program_all(tpfc_pkg::PAL_JET, tpfc_pkg::FMT_RAW16, 16'd0, 16'd0, 16'd0, 16'd255);
        send_pixel(16'd63, 1'b0);
        send_pixel(16'd64, 1'b0);
        send_pixel(16'd191, 1'b0);
        send_pixel(16'd192, 1'b1);
        program_all(tpfc_pkg::PAL_IRON, tpfc_pkg::FMT_RAW16, 16'd0, 16'd0, 16'd0, 16'd255);
        send_pixel(16'd0, 1'b0);
        send_pixel(16'd127, 1'b0);
        send_pixel(16'd128, 1'b0);
        send_pixel(16'd255, 1'b1);
        program_all(tpfc_pkg::PAL_GRAY, tpfc_pkg::FMT_RAW16, 16'd0, 16'd0, 16'd0, 16'd255);
        send_pixel(16'd255, 1'b0);
        // spare palette code should paint jet
        program_all(PAL_SPARE, tpfc_pkg::FMT_RAW16, 16'd0, 16'd0, 16'd0, 16'd255);
        send_pixel(16'd128, 1'b1);
    endtask

    // valid band limits are exclusive on both sides
    task automatic test_band_edges();
        program_all(tpfc_pkg::PAL_JET, tpfc_pkg::FMT_RAW16, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_pixel(tpfc_pkg::BAND_LOW, 1'b0);
        send_pixel(tpfc_pkg::BAND_LOW + 16'd1, 1'b0);
        send_pixel(tpfc_pkg::BAND_HIGH - 16'd1, 1'b0);
        send_pixel(tpfc_pkg::BAND_HIGH, 1'b1);
    endtask

    // collapsed and inverted display ranges act as a span of one
    task automatic test_degenerate_range();
        program_all(tpfc_pkg::PAL_GRAY, tpfc_pkg::FMT_RAW16, 16'd0, 16'd0,
                    16'd30000, 16'd30000);
        send_pixel(16'd30000, 1'b0);
        send_pixel(16'd30001, 1'b0);
        program_all(tpfc_pkg::PAL_JET, tpfc_pkg::FMT_RAW16, 16'd0, 16'd0,
                    16'd40000, 16'd10000);
        send_pixel(16'd40001, 1'b1);
    endtask

    // byte samples: full frame span, empty span and inverted span
    task automatic test_byte_expansion();
        program_all(tpfc_pkg::PAL_IRON, tpfc_pkg::FMT_SCALE8, 16'h0000, 16'hFFFF,
                    16'd0, 16'hFFFF);
        send_pixel(16'hAB00, 1'b0);
        send_pixel(16'h12FF, 1'b0);
        send_pixel(16'h5A80, 1'b1);
        program_all(tpfc_pkg::PAL_JET, tpfc_pkg::FMT_SCALE8, 16'hFFFF, 16'hFFFF,
                    16'd0, 16'hFFFF);
        send_pixel(16'hFF7F, 1'b0);
        program_all(tpfc_pkg::PAL_GRAY, tpfc_pkg::FMT_SCALE8, 16'hFFFF, 16'h0000,
                    16'd0, 16'hFFFF);
        send_pixel(16'h0001, 1'b1);
    endtask

    // writes past the register file must leave every register alone
    task automatic test_spare_addresses();
        program_all(tpfc_pkg::PAL_IRON, tpfc_pkg::FMT_RAW16, 16'd500, 16'd9000,
                    16'd100, 16'd40000);
        set_reg(REG_SPARE_A, 16'($urandom_range(0, 16'hFFFF)));
        set_reg(REG_SPARE_B, 16'($urandom_range(0, 16'hFFFF)));
        for (int i = tpfc_pkg::REG_PALETTE_MODE; i <= tpfc_pkg::REG_RANGE_HIGH; i++)
            check_reg(i[2:0]);
        send_pixel(16'd20000, 1'b1);
    endtask

    // random settings, each followed by a burst of pixels with random idling
    task automatic test_random_sweep();
        logic [1:0]  pal;
        logic        fmt;
        logic [15:0] smin;
        logic [15:0] smax;
        logic [15:0] lo;
        logic [15:0] hi;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pal  = 2'($urandom_range(0, 3));
            fmt  = 1'($urandom_range(0, 1));
            smin = draw_word();
            smax = draw_word();
            case ($urandom_range(0, 3))
                0: smax = smin;
                1: begin
                    smin = 16'h0000;
                    smax = 16'hFFFF;
                end
                default: ;
            endcase
            lo = draw_word();
            hi = draw_word();
            case ($urandom_range(0, 5))
                0: hi = lo;
                1: begin
                    lo = 16'h0000;
                    hi = 16'hFFFF;
                end
                // narrow span of at most 255 counts above the low limit
                2: hi = (lo > 16'hFF00) ? 16'hFFFF : 16'(lo + $urandom_range(1, 255));
                // display range over the byte expansion span
                3: begin
                    lo = smin;
                    hi = smax;
                end
                default: ;
            endcase
            src_idle = 1'($urandom_range(0, 1));
            snk_idle = 1'($urandom_range(0, 1));
            program_all(pal, fmt, smin, smax, lo, hi);
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                send_pixel(draw_sample(), $urandom_range(0, 7) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n           <= 1'b0;
        pix_bus.valid     <= 1'b0;
        pix_bus.sample    <= 16'd0;
        pix_bus.frame_end <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= 32'd0;

        // mirror of the reset values
        cfg_shadow.palette_mode = tpfc_pkg::PAL_JET;
        cfg_shadow.pixel_format = tpfc_pkg::FMT_RAW16;
        cfg_shadow.scaled_min   = 16'd0;
        cfg_shadow.scaled_max   = 16'd0;
        cfg_shadow.range_low    = 16'd0;
        cfg_shadow.range_high   = 16'd1;

        src_idle      = 1'b0;
        snk_idle      = 1'b0;
        pixels_sent   = 0;
        results_seen  = 0;
        mismatches    = 0;
        settings_used = 1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_palette_edges();
        test_band_edges();
        test_degenerate_range();
        test_byte_expansion();
        test_spare_addresses();
        test_random_sweep();

        // all owed colours in, then watch a while for stray transfers
        settle();
        repeat (3 * PIPE_DEPTH) @(posedge i_clk);

        $display("run covered %0d pixels over %0d register settings,", pixels_sent,
                 settings_used);
        $display("all palette codes, raw and byte formats; %0d colours compared, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && colour_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tpfc_pkg.sv
design/tpfc_pix_if.sv
design/tpfc_rgb_if.sv
design/tpfc_decode.sv
design/tpfc_norm.sv
design/tpfc_palette.sv
design/thermal_pixel_false_color.sv
design/tpfc_checker.sv
bench/thermal_pixel_false_color_tb.sv
